// ===== hw/rtl/ebzsd_pkg.sv =====
// Package for the even-byte ZIP stream decrypt unit: types, key constants, CRC helpers.
package ebzsd_pkg;

    localparam logic [31:0] KEY0_INIT = 32'h12345678;
    localparam logic [31:0] KEY1_INIT = 32'h23456789;
    localparam logic [31:0] KEY2_INIT = 32'h34567890;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] KEY1_MULT = 32'h08088405;
    localparam logic [15:0] PAD_MASK  = 16'hFFFD;
    localparam logic [15:0] PAD_SET   = 16'h0002;

    localparam int SEED_LEN = 20;
    localparam logic [7:0] SEED_PHRASE [SEED_LEN] = '{
        8'h6F, 8'h66, 8'h4F, 8'h31, 8'h61, 8'h30, 8'h75, 8'h65, 8'h58, 8'h41,
        8'h3F, 8'h20, 8'h5B, 8'hFF, 8'h73, 8'h20, 8'h68, 8'h20, 8'h25, 8'h3F
    };

    // One reflected CRC-32 byte step
    function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] data);
        logic [31:0] c;
        c = {24'h0, acc[7:0] ^ data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c ^ (acc >> 8);
    endfunction

    // Seed the keys with the fixed password; evaluated at elaboration only
    function automatic logic [95:0] seeded_keys();
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        k0 = KEY0_INIT;
        k1 = KEY1_INIT;
        k2 = KEY2_INIT;
        for (int i = 0; i < SEED_LEN; i++)
        begin
            k0 = crc_byte(k0, SEED_PHRASE[i]);
            k1 = KEY1_MULT * (k1 + {24'h0, k0[7:0]}) + 32'd1;
            k2 = crc_byte(k2, k1[31:24]);
        end
        return {k0, k1, k2};
    endfunction

    localparam logic [95:0] SEED_KEYS = seeded_keys();
    localparam logic [31:0] KEY0_SEED = SEED_KEYS[95:64];
    localparam logic [31:0] KEY1_SEED = SEED_KEYS[63:32];
    localparam logic [31:0] KEY2_SEED = SEED_KEYS[31:0];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_KEY0,
        ST_KEY1,
        ST_KEY2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic calc_pad;
        logic upd_key0;
        logic upd_key1;
        logic upd_key2;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic odd;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/ebzsd_ctrl.sv =====
// Controller state machine sequencing pad generation and key updates.
module ebzsd_ctrl
    import ebzsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd,
    output state_t  state
);

    state_t state_reg;
    state_t state_next;

    // Hold current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through the even-byte steps; odd bytes go straight to done
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.odd ? ST_DONE : ST_PAD;
                end
            end
            ST_PAD:  state_next = ST_KEY0;
            ST_KEY0: state_next = ST_KEY1;
            ST_KEY1: state_next = ST_KEY2;
            ST_KEY2: state_next = ST_DONE;
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_PAD:  cmd.calc_pad = 1'b1;
            ST_KEY0: cmd.upd_key0 = 1'b1;
            ST_KEY1: cmd.upd_key1 = 1'b1;
            ST_KEY2: cmd.upd_key2 = 1'b1;
            ST_DONE: cmd.finish   = status.out_free;
            default: cmd = '0;
        endcase
    end

    assign state = state_reg;

endmodule

// ===== hw/rtl/ebzsd_datapath.sv =====
// Datapath: cipher keys, parity, pad multiply, CRC steps and output register.
module ebzsd_datapath
    import ebzsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output status_t    status,
    input  logic [7:0] cipher_byte,
    input  logic       last_byte,
    output logic [7:0] plain_byte,
    output logic       last,
    output logic       out_valid,
    input  logic       out_ready
);

    logic [31:0] key0_reg;
    logic [31:0] key1_reg;
    logic [31:0] key2_reg;
    logic        odd_reg;
    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_in_reg;
    logic [7:0]  plain_reg;
    logic [31:0] sum_reg;
    logic [7:0]  plain_out_reg;
    logic        last_out_reg;

    logic [15:0] pad_v;
    logic [31:0] pad_prod;
    logic [31:0] key0_next;
    logic [31:0] key1_next;
    logic [31:0] key2_next;
    logic        out_free;

    // Pad from key two
    assign pad_v    = (key2_reg[15:0] & PAD_MASK) | PAD_SET;
    assign pad_prod = {16'h0, pad_v} * {16'h0, pad_v ^ 16'h0001};

    // Key update steps
    assign key0_next = crc_byte(key0_reg, plain_reg);
    assign key1_next = KEY1_MULT * sum_reg + 32'd1;
    assign key2_next = crc_byte(key2_reg, key1_reg[31:24]);

    assign out_free = !out_valid_reg || out_ready;

    // Keys, parity and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg      <= KEY0_SEED;
            key1_reg      <= KEY1_SEED;
            key2_reg      <= KEY2_SEED;
            odd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.upd_key0)
            begin
                key0_reg <= key0_next;
            end
            if (cmd.upd_key1)
            begin
                key1_reg <= key1_next;
            end
            if (cmd.upd_key2)
            begin
                key2_reg <= key2_next;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (last_in_reg)
                begin
                    // Reseed at end of buffer
                    key0_reg <= KEY0_SEED;
                    key1_reg <= KEY1_SEED;
                    key2_reg <= KEY2_SEED;
                    odd_reg  <= 1'b0;
                end
                else
                begin
                    odd_reg <= !odd_reg;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            byte_reg    <= cipher_byte;
            last_in_reg <= last_byte;
        end
        if (cmd.calc_pad)
        begin
            plain_reg <= byte_reg ^ pad_prod[15:8];
        end
        if (cmd.upd_key0)
        begin
            sum_reg <= key1_reg + {24'h0, key0_next[7:0]};
        end
        if (cmd.finish)
        begin
            plain_out_reg <= odd_reg ? byte_reg : plain_reg;
            last_out_reg  <= last_in_reg;
        end
    end

    assign status.odd      = odd_reg;
    assign status.out_free = out_free;
    assign plain_byte      = plain_out_reg;
    assign last            = last_out_reg;
    assign out_valid       = out_valid_reg;

endmodule

// ===== hw/rtl/even_byte_zip_stream_decrypt_unit.sv =====
// Top level of the even-byte ZIP stream decrypt unit.
// Odd-position bytes go from accept through the done state to out_valid; even-position bytes
// first pass through the pad, key-zero, key-one and key-two states. One transaction at a time,
// with the pad multiply, the key-one multiply and the two CRC steps run in sequence.
// The output register lets the next transaction enter while a result waits.
// Reset (rst_n low, asynchronous) loads the password-seeded keys and clears parity.
module even_byte_zip_stream_decrypt_unit
    import ebzsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] cipher_byte,
    input  logic       last_byte,
    input  logic       in_valid,
    output logic       in_ready,
    output logic [7:0] plain_byte,
    output logic       last,
    output logic       out_valid,
    input  logic       out_ready
);

    cmd_t    cmd;
    status_t status;
    state_t  state;

    ebzsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    ebzsd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cipher_byte (cipher_byte),
        .last_byte   (last_byte),
        .plain_byte  (plain_byte),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

    // One transaction in flight: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a transaction is in flight");

    // Never overwrite an unread result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid || out_ready))
        else $error("result loaded over a pending output");

    // Even-position bytes go through the pad step
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !status.odd) |=> (state == ST_PAD))
        else $error("even byte skipped pad generation");

endmodule
